@@ hdl/packet_split_marker_defines.svh @@
// assertion macros shared by the checker of packet_split_marker
// the checker scope provides clk and rst
`ifndef PACKET_SPLIT_MARKER_DEFINES_SVH
`define PACKET_SPLIT_MARKER_DEFINES_SVH

// same-cycle implication, off during reset
`define PSM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psm checker: same-cycle property failed");

// next-cycle implication, off during reset
`define PSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psm checker: next-cycle property failed");

`endif

@@ hdl/psm_pkg.sv @@
// shared types and constants for packet_split_marker
// no dependencies
`default_nettype none

package psm_pkg;

  localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] PORT_HTTPS     = 16'd443;
  localparam logic [15:0] PORT_HTTP      = 16'd80;
  localparam logic [15:0] PORT_DNS       = 16'd53;
  localparam logic [7:0]  ETH_HDR_BYTES  = 8'd14;
  localparam logic [7:0]  ETH_IP_MIN     = 8'd34;
  localparam logic [7:0]  UDP_HDR_BYTES  = 8'd8;
  localparam logic [15:0] TCP_EXTRA      = 16'd64;
  localparam logic [15:0] OTHER_EXTRA    = 16'd16;
  localparam int          DIV_BITS       = 32;
  localparam int          DIV_CNT_W      = $clog2(DIV_BITS);

  localparam logic [1:0] STRAT_RANDOM = 2'd1;
  localparam logic [1:0] STRAT_PROTO  = 2'd2;

  // rule mask bits
  localparam int RULE_HTTPS = 0;
  localparam int RULE_HTTP  = 1;
  localparam int RULE_SYN   = 2;
  localparam int RULE_DNS   = 3;
  localparam int RULE_QUIC  = 4;

  typedef enum logic [2:0] {
    REG_ENABLE     = 3'd0,
    REG_MIN_LENGTH = 3'd1,
    REG_RULE_MASK  = 3'd2,
    REG_STRATEGY   = 3'd3,
    REG_OFFSET     = 3'd4,
    REG_MIN_PIECE  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

  typedef struct packed {
    logic inc;
    logic tcp;
    logic udp;
  } stat_upd_t;

endpackage

`default_nettype wire

@@ hdl/packet_split_marker.sv @@
// packet_split_marker top level: config registers, sequencer, hash and position
// depends on psm_pkg, psm_mod_unit, psm_stats
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//   in      | in_valid/in_ready    | parsed header fields, one packet a request
//   out     | out_valid/out_ready  | mark, split_position, hash, four totals
//
// one packet at a time; a marked packet runs the hash and, under the random strategy,
// may run the 32-step serial modulo unit; a result can stall on out_ready
// the hash takes 2 or 4 multiply-by-31 steps on a 64-bit shift-subtract-add
// synchronous reset clears config registers, counters and the sequencer
// in_ready is low from acceptance until the result request is taken
`default_nettype none

module packet_split_marker
  import psm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] ethertype,
  input  wire logic [15:0] captured_length,
  input  wire logic [15:0] packet_length,
  input  wire logic [3:0]  ip_header_words,
  input  wire logic [7:0]  protocol,
  input  wire logic [31:0] source_address,
  input  wire logic [31:0] destination_address,
  input  wire logic [15:0] source_port_raw,
  input  wire logic [15:0] destination_port_raw,
  input  wire logic        syn_flag,
  input  wire logic [3:0]  tcp_header_words,
  input  wire logic [31:0] random_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             mark,
  output logic [31:0]      split_position,
  output logic [63:0]      connection_hash,
  output logic [31:0]      marked_total,
  output logic [31:0]      pieces_total,
  output logic [31:0]      tcp_marked_total,
  output logic [31:0]      udp_marked_total
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_HASH   = 7'b0000100,
    S_SPAN   = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_FIN    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // config registers
  logic        enable;
  logic [15:0] min_packet_length;
  logic [4:0]  rule_mask;
  logic [1:0]  split_strategy;
  logic [15:0] split_offset;
  logic [15:0] min_piece_size;

  // captured request
  logic [15:0] etype_r;
  logic [15:0] cap_r;
  logic [15:0] plen_r;
  logic [3:0]  ihl_r;
  logic [7:0]  proto_r;
  logic [31:0] sa_r;
  logic [31:0] da_r;
  logic [15:0] sp_r;
  logic [15:0] dpr_r;
  logic        syn_r;
  logic [3:0]  doff_r;
  logic [31:0] rnd_r;

  logic [7:0]  start_pos;
  logic [31:0] rnd_off;
  logic [1:0]  hash_step;

  logic        is_tcp;
  logic        is_udp;
  logic [15:0] dport;
  logic [16:0] hdr_need;
  logic [7:0]  l4_len;
  logic [7:0]  start_calc;
  logic        rule_ok;
  logic        mark_calc;
  logic [31:0] hash_add;
  logic [63:0] hash_next;
  logic [1:0]  hash_last;
  logic [31:0] span;
  logic [15:0] base_off;
  logic [31:0] pos_calc;

  mod_stat_t   mod_stat;
  logic        mod_start;
  logic [31:0] mod_rem;
  stat_upd_t   upd;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable            <= 1'b0;
      min_packet_length <= '0;
      rule_mask         <= '0;
      split_strategy    <= '0;
      split_offset      <= '0;
      min_piece_size    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE:     enable            <= cfg_data[0];
        REG_MIN_LENGTH: min_packet_length <= cfg_data;
        REG_RULE_MASK:  rule_mask         <= cfg_data[4:0];
        REG_STRATEGY:   split_strategy    <= cfg_data[1:0];
        REG_OFFSET:     split_offset      <= cfg_data;
        REG_MIN_PIECE:  min_piece_size    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      etype_r <= ethertype;
      cap_r   <= captured_length;
      plen_r  <= packet_length;
      ihl_r   <= ip_header_words;
      proto_r <= protocol;
      sa_r    <= source_address;
      da_r    <= destination_address;
      sp_r    <= source_port_raw;
      dpr_r   <= destination_port_raw;
      syn_r   <= syn_flag;
      doff_r  <= tcp_header_words;
      rnd_r   <= random_value;
    end
  end

  // decision logic on the captured request
  assign is_tcp   = (proto_r == PROTO_TCP);
  assign is_udp   = (proto_r == PROTO_UDP);
  assign dport    = {dpr_r[7:0], dpr_r[15:8]};
  assign hdr_need = 17'(ETH_HDR_BYTES) + 17'({ihl_r, 2'b00}) + 17'(UDP_HDR_BYTES);
  assign l4_len   = is_tcp ? {2'b00, doff_r, 2'b00} : (is_udp ? UDP_HDR_BYTES : 8'd0);
  assign start_calc = ETH_HDR_BYTES + {2'b00, ihl_r, 2'b00} + l4_len;

  always_comb begin
    rule_ok = 1'b0;
    if (is_tcp) begin
      rule_ok = (rule_mask[RULE_HTTPS] && dport == PORT_HTTPS)
             || (rule_mask[RULE_HTTP] && dport == PORT_HTTP)
             || (rule_mask[RULE_SYN] && syn_r);
    end else if (is_udp) begin
      rule_ok = (rule_mask[RULE_DNS] && dport == PORT_DNS)
             || (rule_mask[RULE_QUIC] && (dport == PORT_HTTPS || dport == PORT_HTTP));
    end
  end

  assign mark_calc = (etype_r == ETYPE_IPV4)
                  && (cap_r >= 16'(ETH_IP_MIN))
                  && ({1'b0, cap_r} >= hdr_need)
                  && enable
                  && (plen_r >= min_packet_length)
                  && rule_ok;

  // h * 31 + addend, one field per step
  always_comb begin
    unique case (hash_step)
      2'd0:    hash_add = da_r;
      2'd1:    hash_add = {24'd0, proto_r};
      2'd2:    hash_add = {16'd0, sp_r};
      default: hash_add = {16'd0, dpr_r};
    endcase
  end

  assign hash_next = {connection_hash[58:0], 5'd0} - connection_hash + {32'd0, hash_add};
  assign hash_last = (is_tcp || is_udp) ? 2'd3 : 2'd1;

  assign span = {16'd0, plen_r} - {24'd0, start_pos} - {16'd0, min_piece_size};

  always_comb begin
    if (split_strategy == STRAT_RANDOM) begin
      base_off = min_piece_size;
    end else if (split_strategy == STRAT_PROTO) begin
      base_off = is_tcp ? TCP_EXTRA : OTHER_EXTRA;
    end else begin
      base_off = split_offset;
    end
  end

  assign pos_calc = {24'd0, start_pos} + {16'd0, base_off} + rnd_off;

  assign mod_start = (state == S_SPAN) && (split_strategy == STRAT_RANDOM)
                  && (span >= {16'd0, min_piece_size}) && (span != 32'd0);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_DECIDE;
      S_DECIDE: state_next = mark_calc ? S_HASH : S_OUT;
      S_HASH:   if (hash_step == hash_last) state_next = S_SPAN;
      S_SPAN:   state_next = mod_start ? S_DIV : S_FIN;
      S_DIV:    if (mod_stat.done) state_next = S_FIN;
      S_FIN:    state_next = S_OUT;
      S_OUT:    if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_DECIDE: begin
        mark            <= mark_calc;
        start_pos       <= start_calc;
        hash_step       <= 2'd0;
        split_position  <= '0;
        connection_hash <= mark_calc ? {32'd0, sa_r} : 64'd0;
      end
      S_HASH: begin
        connection_hash <= hash_next;
        hash_step       <= hash_step + 2'd1;
      end
      S_SPAN: begin
        // random offset is zero unless the strategy draws one
        if (split_strategy == STRAT_RANDOM && span >= {16'd0, min_piece_size}
            && span == 32'd0) begin
          rnd_off <= rnd_r;
        end else begin
          rnd_off <= '0;
        end
      end
      S_DIV: begin
        if (mod_stat.done) rnd_off <= mod_rem;
      end
      S_FIN: begin
        split_position <= pos_calc;
      end
      default: ;
    endcase
  end

  assign upd.inc = (state == S_FIN);
  assign upd.tcp = is_tcp;
  assign upd.udp = is_udp;

  psm_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (rnd_r),
    .divisor   (span),
    .stat      (mod_stat),
    .remainder (mod_rem)
  );

  psm_stats u_stats (
    .clk              (clk),
    .rst              (rst),
    .upd              (upd),
    .marked_total     (marked_total),
    .pieces_total     (pieces_total),
    .tcp_marked_total (tcp_marked_total),
    .udp_marked_total (udp_marked_total)
  );

endmodule

`default_nettype wire

@@ hdl/psm_mod_unit.sv @@
// serial restoring modulo unit, one remainder bit per cycle
// depends on psm_pkg
`default_nettype none

module psm_mod_unit
  import psm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [DIV_BITS-1:0] dividend,
  input  wire logic [DIV_BITS-1:0] divisor,
  output mod_stat_t                stat,
  output logic      [DIV_BITS-1:0] remainder
);

  logic [DIV_BITS-1:0]  rem;
  logic [DIV_BITS-1:0]  quo;
  logic [DIV_BITS-1:0]  dvs;
  logic [DIV_CNT_W-1:0] count;
  logic                 busy;
  logic                 done;
  logic [DIV_BITS:0]    shifted;
  logic [DIV_BITS:0]    trial;

  assign shifted = {rem, quo[DIV_BITS-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == DIV_CNT_W'(DIV_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_BITS-2:0], 1'b0};
      // keep the trial difference when it did not borrow
      if (!trial[DIV_BITS]) begin
        rem <= trial[DIV_BITS-1:0];
      end else begin
        rem <= shifted[DIV_BITS-1:0];
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign remainder = rem;

endmodule

`default_nettype wire

@@ hdl/psm_stats.sv @@
// wrapping statistics counters for marked packets
// depends on psm_pkg
`default_nettype none

module psm_stats
  import psm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  stat_upd_t        upd,
  output logic      [31:0] marked_total,
  output logic      [31:0] pieces_total,
  output logic      [31:0] tcp_marked_total,
  output logic      [31:0] udp_marked_total
);

  always_ff @(posedge clk) begin
    if (rst) begin
      marked_total     <= '0;
      pieces_total     <= '0;
      tcp_marked_total <= '0;
      udp_marked_total <= '0;
    end else if (upd.inc) begin
      marked_total <= marked_total + 32'd1;
      pieces_total <= pieces_total + 32'd2;
      if (upd.tcp) begin
        tcp_marked_total <= tcp_marked_total + 32'd1;
      end
      if (upd.udp) begin
        udp_marked_total <= udp_marked_total + 32'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/psm_checker.sv @@
// port-level checker for packet_split_marker, bound to the top level
// depends on packet_split_marker_defines.svh
`default_nettype none

`include "packet_split_marker_defines.svh"

module psm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        mark,
  input wire logic [31:0] split_position,
  input wire logic [63:0] connection_hash,
  input wire logic [31:0] marked_total,
  input wire logic [31:0] pieces_total
);

  // an unmarked packet carries no position and no hash
  `PSM_ASSERT_NOW(a_unmarked_zero, out_valid && !mark,
                  split_position == 32'd0 && connection_hash == 64'd0)

  // two pieces are counted for every marked packet
  `PSM_ASSERT_NOW(a_pieces_double, out_valid, pieces_total == (marked_total << 1))

  // one packet in flight: no new request while a result waits
  `PSM_ASSERT_NOW(a_no_overlap, out_valid, !in_ready)

  // a stalled result holds its position
  `PSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(split_position))

endmodule

bind packet_split_marker psm_checker u_psm_checker (.*);

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench for packet_split_marker: directed and random header requests
// run through an independent predictor with randomized input gaps and output stalls
// depends on psm_pkg and the packet_split_marker rtl

module testbench;
  import psm_pkg::*;

  localparam logic [1:0]  STRAT_FIXED     = 2'd0;
  localparam logic [1:0]  STRAT_FIXED_ALT = 2'd3;
  localparam logic [15:0] PORT_SSH        = 16'd22;
  localparam logic [7:0]  PROTO_ICMP      = 8'd1;
  localparam logic [63:0] HASH_MULT       = 64'd31;
  localparam logic [15:0] ETYPE_IPV6      = 16'h86dd;
  localparam int          CYCLE_LIMIT     = 1000000;
  localparam int          DRAIN_CYCLES    = 60;

  typedef struct {
    logic [15:0] ethertype;
    logic [15:0] captured_length;
    logic [15:0] packet_length;
    logic [3:0]  ip_header_words;
    logic [7:0]  protocol;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port_raw;
    logic [15:0] destination_port_raw;
    logic        syn_flag;
    logic [3:0]  tcp_header_words;
    logic [31:0] random_value;
  } pkt_t;

  typedef struct {
    logic        mark;
    logic [31:0] split_position;
    logic [63:0] connection_hash;
    logic [31:0] marked_total;
    logic [31:0] pieces_total;
    logic [31:0] tcp_marked_total;
    logic [31:0] udp_marked_total;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] ethertype = '0;
  logic [15:0] captured_length = '0;
  logic [15:0] packet_length = '0;
  logic [3:0]  ip_header_words = '0;
  logic [7:0]  protocol = '0;
  logic [31:0] source_address = '0;
  logic [31:0] destination_address = '0;
  logic [15:0] source_port_raw = '0;
  logic [15:0] destination_port_raw = '0;
  logic        syn_flag = 1'b0;
  logic [3:0]  tcp_header_words = '0;
  logic [31:0] random_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        mark;
  logic [31:0] split_position;
  logic [63:0] connection_hash;
  logic [31:0] marked_total;
  logic [31:0] pieces_total;
  logic [31:0] tcp_marked_total;
  logic [31:0] udp_marked_total;

  // predictor copy of the registers and counters
  logic        cfg_enable = 1'b0;
  logic [15:0] cfg_min_length = '0;
  logic [4:0]  cfg_rule_mask = '0;
  logic [1:0]  cfg_strategy = '0;
  logic [15:0] cfg_split_offset = '0;
  logic [15:0] cfg_min_piece = '0;
  logic [31:0] count_marked = '0;
  logic [31:0] count_pieces = '0;
  logic [31:0] count_tcp = '0;
  logic [31:0] count_udp = '0;

  verdict_t expected_verdicts[$];
  verdict_t oldest;
  int mismatch_count = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  packet_split_marker i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .ethertype           (ethertype),
    .captured_length     (captured_length),
    .packet_length       (packet_length),
    .ip_header_words     (ip_header_words),
    .protocol            (protocol),
    .source_address      (source_address),
    .destination_address (destination_address),
    .source_port_raw     (source_port_raw),
    .destination_port_raw(destination_port_raw),
    .syn_flag            (syn_flag),
    .tcp_header_words    (tcp_header_words),
    .random_value        (random_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .mark                (mark),
    .split_position      (split_position),
    .connection_hash     (connection_hash),
    .marked_total        (marked_total),
    .pieces_total        (pieces_total),
    .tcp_marked_total    (tcp_marked_total),
    .udp_marked_total    (udp_marked_total)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: long hold-off when asked, otherwise random stalls
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic verdict_t predict_verdict(input pkt_t p);
    verdict_t v;
    logic [15:0] dport;
    logic [31:0] need;
    logic [31:0] l4_bytes;
    logic [31:0] start;
    logic [31:0] span;
    logic [63:0] h;
    logic        is_tcp;
    logic        is_udp;
    logic        rule_hit;
    is_tcp = (p.protocol == PROTO_TCP);
    is_udp = (p.protocol == PROTO_UDP);
    dport = {p.destination_port_raw[7:0], p.destination_port_raw[15:8]};
    need = 32'(ETH_HDR_BYTES) + {26'd0, p.ip_header_words, 2'b00} + 32'(UDP_HDR_BYTES);
    rule_hit = is_tcp && ((cfg_rule_mask[RULE_HTTPS] && dport == PORT_HTTPS) ||
                          (cfg_rule_mask[RULE_HTTP] && dport == PORT_HTTP) ||
                          (cfg_rule_mask[RULE_SYN] && p.syn_flag));
    rule_hit |= is_udp && ((cfg_rule_mask[RULE_DNS] && dport == PORT_DNS) ||
                           (cfg_rule_mask[RULE_QUIC] &&
                            (dport == PORT_HTTPS || dport == PORT_HTTP)));
    v.mark = (p.ethertype == ETYPE_IPV4) && ({16'd0, p.captured_length} >= need) &&
             (p.captured_length >= 16'(ETH_IP_MIN)) && cfg_enable &&
             (p.packet_length >= cfg_min_length) && rule_hit;
    v.split_position = '0;
    v.connection_hash = '0;
    if (v.mark) begin
      h = {32'd0, p.source_address};
      h = h * HASH_MULT + {32'd0, p.destination_address};
      h = h * HASH_MULT + {56'd0, p.protocol};
      if (is_tcp || is_udp) begin
        h = h * HASH_MULT + {48'd0, p.source_port_raw};
        h = h * HASH_MULT + {48'd0, p.destination_port_raw};
      end
      v.connection_hash = h;
      l4_bytes = is_tcp ? {26'd0, p.tcp_header_words, 2'b00} :
                 is_udp ? 32'(UDP_HDR_BYTES) : 32'd0;
      start = 32'(ETH_HDR_BYTES) + {26'd0, p.ip_header_words, 2'b00} + l4_bytes;
      case (cfg_strategy)
        STRAT_RANDOM: begin
          // span wraps at 32 bits when the packet is shorter than the headers
          span = {16'd0, p.packet_length} - start - {16'd0, cfg_min_piece};
          if (span < {16'd0, cfg_min_piece})
            v.split_position = start + {16'd0, cfg_min_piece};
          else
            v.split_position = start + {16'd0, cfg_min_piece} +
                               ((span == 32'd0) ? p.random_value : p.random_value % span);
        end
        STRAT_PROTO: begin
          v.split_position = start + {16'd0, (is_tcp ? TCP_EXTRA : OTHER_EXTRA)};
        end
        default: begin
          v.split_position = start + {16'd0, cfg_split_offset};
        end
      endcase
      count_marked += 32'd1;
      count_pieces += 32'd2;
      if (is_tcp) count_tcp += 32'd1;
      else if (is_udp) count_udp += 32'd1;
    end
    v.marked_total = count_marked;
    v.pieces_total = count_pieces;
    v.tcp_marked_total = count_tcp;
    v.udp_marked_total = count_udp;
    return v;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t result request with nothing expected", $time);
        mismatch_count++;
      end else begin
        oldest = expected_verdicts.pop_front();
        check_field("mark", 64'(oldest.mark), 64'(mark));
        check_field("split_position", 64'(oldest.split_position), 64'(split_position));
        check_field("connection_hash", oldest.connection_hash, connection_hash);
        check_field("marked_total", 64'(oldest.marked_total), 64'(marked_total));
        check_field("pieces_total", 64'(oldest.pieces_total), 64'(pieces_total));
        check_field("tcp_marked_total", 64'(oldest.tcp_marked_total),
                    64'(tcp_marked_total));
        check_field("udp_marked_total", 64'(oldest.udp_marked_total),
                    64'(udp_marked_total));
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ENABLE:     cfg_enable = val[0];
      REG_MIN_LENGTH: cfg_min_length = val;
      REG_RULE_MASK:  cfg_rule_mask = val[4:0];
      REG_STRATEGY:   cfg_strategy = val[1:0];
      REG_OFFSET:     cfg_split_offset = val;
      REG_MIN_PIECE:  cfg_min_piece = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_packet(input pkt_t p);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    ethertype <= p.ethertype;
    captured_length <= p.captured_length;
    packet_length <= p.packet_length;
    ip_header_words <= p.ip_header_words;
    protocol <= p.protocol;
    source_address <= p.source_address;
    destination_address <= p.destination_address;
    source_port_raw <= p.source_port_raw;
    destination_port_raw <= p.destination_port_raw;
    syn_flag <= p.syn_flag;
    tcp_header_words <= p.tcp_header_words;
    random_value <= p.random_value;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_verdicts.push_back(predict_verdict(p));
  endtask

  // drop the request line and wait for every result to come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
  endtask

  function automatic pkt_t make_packet(input logic [7:0] proto, input logic [15:0] dport,
                                       input logic syn);
    pkt_t p;
    p.ethertype = ETYPE_IPV4;
    p.captured_length = 16'd1514;
    p.packet_length = 16'd1514;
    p.ip_header_words = 4'd5;
    p.protocol = proto;
    p.source_address = $urandom;
    p.destination_address = $urandom;
    p.source_port_raw = 16'($urandom);
    p.destination_port_raw = {dport[7:0], dport[15:8]};
    p.syn_flag = syn;
    p.tcp_header_words = 4'd5;
    p.random_value = $urandom;
    return p;
  endfunction

  function automatic pkt_t random_packet();
    pkt_t p;
    logic [15:0] dport;
    logic [7:0] proto;
    int hdr;
    int floor_cap;
    int pick;
    // some pure noise
    if ($urandom_range(9) == 0) begin
      p.ethertype = 16'($urandom);
      p.captured_length = 16'($urandom);
      p.packet_length = 16'($urandom);
      p.ip_header_words = 4'($urandom);
      p.protocol = 8'($urandom);
      p.source_address = $urandom;
      p.destination_address = $urandom;
      p.source_port_raw = 16'($urandom);
      p.destination_port_raw = 16'($urandom);
      p.syn_flag = 1'($urandom);
      p.tcp_header_words = 4'($urandom);
      p.random_value = $urandom;
      return p;
    end
    pick = $urandom_range(3);
    dport = (pick == 0) ? PORT_HTTPS : (pick == 1) ? PORT_HTTP :
            (pick == 2) ? PORT_DNS : 16'($urandom);
    pick = $urandom_range(9);
    proto = (pick < 4) ? PROTO_TCP : (pick < 8) ? PROTO_UDP : 8'($urandom);
    p = make_packet(proto, dport, 1'($urandom));
    if ($urandom_range(19) == 0) p.ethertype = 16'($urandom);
    if ($urandom_range(4) == 0) p.ip_header_words = 4'($urandom);
    p.tcp_header_words = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(15, 5));
    hdr = 14 + 4 * int'(p.ip_header_words) +
          ((proto == PROTO_TCP) ? 4 * int'(p.tcp_header_words) : 8);
    case ($urandom_range(4))
      0: p.packet_length = 16'($urandom);
      1: p.packet_length = 16'($urandom_range(hdr + 64));
      default: p.packet_length = 16'($urandom_range(1514, hdr));
    endcase
    floor_cap = 14 + 4 * int'(p.ip_header_words) + 8;
    if (floor_cap < 34) floor_cap = 34;
    case ($urandom_range(9))
      0: p.captured_length = 16'($urandom);
      1: p.captured_length = 16'($urandom_range(90));
      default: p.captured_length = (int'(p.packet_length) > floor_cap) ?
                                   p.packet_length : 16'(floor_cap);
    endcase
    if ($urandom_range(2) == 0) p.random_value = $urandom_range(2000);
    return p;
  endfunction

  task automatic randomize_settings();
    int pick;
    write_reg(REG_ENABLE, 16'($urandom_range(9) != 0));
    pick = $urandom_range(19);
    write_reg(REG_MIN_LENGTH, (pick == 0) ? 16'hffff :
                              (pick < 8) ? 16'd0 : 16'($urandom_range(1500)));
    pick = $urandom_range(9);
    write_reg(REG_RULE_MASK, (pick == 0) ? 16'd0 : (pick < 5) ? 16'd31 :
                             16'($urandom_range(31)));
    write_reg(REG_STRATEGY, 16'($urandom_range(3)));
    pick = $urandom_range(5);
    write_reg(REG_OFFSET, (pick == 0) ? 16'd0 : (pick == 1) ? 16'hffff :
                          16'($urandom));
    pick = $urandom_range(7);
    write_reg(REG_MIN_PIECE, (pick == 0) ? 16'd0 : (pick == 1) ? 16'hffff :
                             16'($urandom_range(400)));
  endtask

  task automatic test_header_checks();
    pkt_t p;
    write_reg(REG_ENABLE, 16'd1);
    write_reg(REG_MIN_LENGTH, 16'd0);
    write_reg(REG_RULE_MASK, 16'd31);
    write_reg(REG_STRATEGY, 16'(STRAT_FIXED));
    write_reg(REG_OFFSET, 16'd0);
    write_reg(REG_MIN_PIECE, 16'd0);
    send_packet(make_packet(PROTO_TCP, PORT_HTTPS, 1'b0));
    p = make_packet(PROTO_TCP, PORT_HTTPS, 1'b0);
    p.captured_length = 16'd13;
    send_packet(p);
    p.captured_length = 16'd33;
    send_packet(p);
    // longest ip header, capture one byte short, then just enough
    p.ip_header_words = 4'd15;
    p.captured_length = 16'd81;
    send_packet(p);
    p.captured_length = 16'd82;
    send_packet(p);
    p = make_packet(PROTO_TCP, PORT_HTTPS, 1'b0);
    p.ethertype = ETYPE_IPV6;
    send_packet(p);
    // ip header length below the legal minimum is used as given
    p.ethertype = ETYPE_IPV4;
    p.ip_header_words = 4'd0;
    send_packet(p);
    p = '{default: '0};
    send_packet(p);
    p = '{ethertype: 16'hffff, captured_length: 16'hffff, packet_length: 16'hffff,
          ip_header_words: 4'hf, protocol: 8'hff, source_address: '1,
          destination_address: '1, source_port_raw: '1, destination_port_raw: '1,
          syn_flag: 1'b1, tcp_header_words: 4'hf, random_value: '1};
    send_packet(p);
    settle();
  endtask

  task automatic test_rules();
    send_packet(make_packet(PROTO_TCP, PORT_HTTP, 1'b0));
    send_packet(make_packet(PROTO_TCP, PORT_SSH, 1'b1));
    send_packet(make_packet(PROTO_TCP, PORT_SSH, 1'b0));
    send_packet(make_packet(PROTO_UDP, PORT_DNS, 1'b0));
    send_packet(make_packet(PROTO_UDP, PORT_HTTPS, 1'b0));
    send_packet(make_packet(PROTO_UDP, PORT_HTTP, 1'b0));
    send_packet(make_packet(PROTO_UDP, PORT_SSH, 1'b1));
    send_packet(make_packet(PROTO_ICMP, PORT_HTTPS, 1'b1));
    settle();
    write_reg(REG_RULE_MASK, 16'd0);
    send_packet(make_packet(PROTO_TCP, PORT_HTTPS, 1'b1));
    settle();
    write_reg(REG_RULE_MASK, 16'd31);
  endtask

  task automatic test_split_strategies();
    pkt_t p;
    write_reg(REG_STRATEGY, 16'(STRAT_RANDOM));
    // zero span hands back the random word itself
    p = make_packet(PROTO_UDP, PORT_DNS, 1'b0);
    p.packet_length = 16'd42;
    send_packet(p);
    settle();
    write_reg(REG_MIN_PIECE, 16'd100);
    p.packet_length = 16'd300;
    send_packet(p);
    settle();
    write_reg(REG_MIN_PIECE, 16'd200);
    send_packet(p);
    settle();
    // span wraps and the position sum overflows
    write_reg(REG_MIN_PIECE, 16'hffff);
    p.random_value = 32'hffff_0088;
    send_packet(p);
    settle();
    write_reg(REG_STRATEGY, 16'(STRAT_PROTO));
    send_packet(make_packet(PROTO_TCP, PORT_HTTPS, 1'b0));
    send_packet(make_packet(PROTO_UDP, PORT_HTTPS, 1'b0));
    settle();
    write_reg(REG_STRATEGY, 16'(STRAT_FIXED_ALT));
    write_reg(REG_OFFSET, 16'hffff);
    send_packet(make_packet(PROTO_TCP, PORT_HTTP, 1'b0));
    settle();
  endtask

  task automatic test_gating();
    pkt_t p;
    write_reg(REG_ENABLE, 16'd0);
    send_packet(make_packet(PROTO_TCP, PORT_HTTPS, 1'b1));
    settle();
    write_reg(REG_ENABLE, 16'd1);
    write_reg(REG_MIN_LENGTH, 16'hffff);
    p = make_packet(PROTO_TCP, PORT_HTTPS, 1'b0);
    p.packet_length = 16'hfffe;
    send_packet(p);
    p.packet_length = 16'hffff;
    send_packet(p);
    settle();
  endtask

  task automatic run_traffic_phase(input int idle, input int stall);
    idle_pct = idle;
    stall_pct = stall;
    repeat (5) begin
      settle();
      randomize_settings();
      repeat (100) send_packet(random_packet());
    end
    settle();
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(0, 0);
    run_traffic_phase(64, 0);
    run_traffic_phase(0, 64);
    run_traffic_phase(27, 27);
  endtask

  // result side held off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    write_reg(REG_ENABLE, 16'd1);
    write_reg(REG_MIN_LENGTH, 16'd0);
    write_reg(REG_RULE_MASK, 16'd31);
    write_reg(REG_STRATEGY, 16'(STRAT_RANDOM));
    write_reg(REG_MIN_PIECE, 16'd10);
    hold_request = 400;
    repeat (8) send_packet(random_packet());
    settle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_header_checks();
    test_rules();
    test_split_strategies();
    test_gating();
    test_backpressure();
    test_random_traffic();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
